// File: rtl/vrds_pkg.sv
package vrds_pkg;

   localparam int WHOLE_BITS      = 31;
   localparam int FRACTION_BITS   = 24;
   localparam int FRACTION_DIGITS = 7;

   localparam int RADIX_W     = 6;
   localparam int THRESHOLD_W = FRACTION_BITS;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CHAR_W      = 7;
   localparam int DIGIT_W     = RADIX_W;
   localparam int PRODUCT_W   = FRACTION_BITS + RADIX_W;

   localparam int STEP_CNT_W  = $clog2(WHOLE_BITS);
   localparam int STACK_CNT_W = $clog2(WHOLE_BITS + 1);
   localparam int STACK_IDX_W = $clog2(WHOLE_BITS);
   localparam int FRAC_CNT_W  = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = CSR_INDEX_W'(1);

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(87);
   localparam logic [CHAR_W-1:0] CHAR_POINT  = CHAR_W'(46);

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      logic                  done;
      logic [WHOLE_BITS-1:0] quotient;
      digit_type             remainder;
   } div_status_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input digit_type d);
      logic [CHAR_W-1:0] wide;
      wide = CHAR_W'(d);
      if (d < DIGIT_W'(10)) begin
         return CHAR_ZERO + wide;
      end
      return CHAR_LETTER + wide;
   endfunction

endpackage

// File: rtl/vrds_divider.sv
module vrds_divider
   import vrds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WHOLE_BITS-1:0] dividend,
   input  logic [RADIX_W-1:0]    divisor,
   output div_status_type        status
);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   logic [WHOLE_BITS-1:0] quo_ff, quo_in;
   digit_type             rem_ff, rem_in;
   logic [RADIX_W-1:0]    divisor_ff, divisor_in;
   logic [RADIX_W:0]      shifted;
   logic [RADIX_W:0]      diff;
   logic                  fits;

   always_comb begin
      shifted    = {rem_ff, quo_ff[WHOLE_BITS-1]};
      diff       = shifted - {1'b0, divisor_ff};
      fits       = shifted >= {1'b0, divisor_ff};
      run_in     = run_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         run_in     = 1'b1;
         step_in    = STEP_CNT_W'(WHOLE_BITS - 1);
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
         quo_in = {quo_ff[WHOLE_BITS-2:0], fits};
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

endmodule

// File: rtl/value_to_radix_digit_string.sv
// Converts an unsigned fixed-point number (31-bit whole part, 24-bit fraction) to its ASCII
// string in radix 2 to 36, most significant digit first, one character per word on the rsp_
// ports with rsp_last_char on the final word. The receiver cannot stall: each word is shown
// for exactly one cycle. A number is taken when start is high and busy is low; busy stays high
// until the last word is issued. Each whole digit is the remainder from the shared bit-serial
// divider (one quotient bit per cycle), which divides the whole part by the radix.
module value_to_radix_digit_string
   import vrds_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [WHOLE_BITS-1:0]    req_whole_value,
   input  logic [FRACTION_BITS-1:0] req_fraction_value,
   output logic                     rsp_valid,
   output logic [CHAR_W-1:0]        rsp_digit_char,
   output logic                     rsp_last_char,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DIV_START = 3'd1;
   localparam logic [2:0] S_DIV_WAIT  = 3'd2;
   localparam logic [2:0] S_WHOLE     = 3'd3;
   localparam logic [2:0] S_DOT       = 3'd4;
   localparam logic [2:0] S_FRAC      = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [RADIX_W-1:0]       radix_csr_ff, radix_csr_in;
   logic [THRESHOLD_W-1:0]   thresh_csr_ff, thresh_csr_in;
   logic [RADIX_W-1:0]       radix_ff, radix_in;
   logic [WHOLE_BITS-1:0]    whole_ff, whole_in;
   logic [FRACTION_BITS-1:0] frac_ff, frac_in;
   logic                     frac_more_ff, frac_more_in;
   logic [STACK_CNT_W-1:0]   depth_ff, depth_in;
   logic [FRAC_CNT_W-1:0]    frac_cnt_ff, frac_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]        rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;
   digit_type                digit_stack [WHOLE_BITS];
   logic [STACK_IDX_W-1:0]   pop_idx;
   logic                     push;
   logic                     div_start;
   div_status_type           div_status;
   logic [PRODUCT_W-1:0]     product;
   logic [FRACTION_BITS-1:0] frac_next;
   logic [RADIX_W-1:0]       radix_eff;

   vrds_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (whole_ff),
      .divisor  (radix_ff),
      .status   (div_status)
   );

   always_comb begin
      if (radix_csr_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (radix_csr_ff > RADIX_MAX) begin
         radix_eff = RADIX_MAX;
      end else begin
         radix_eff = radix_csr_ff;
      end
   end

   assign product   = PRODUCT_W'(frac_ff) * PRODUCT_W'(radix_ff);
   assign frac_next = product[FRACTION_BITS-1:0];
   assign pop_idx   = STACK_IDX_W'(depth_ff - STACK_CNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      radix_csr_in  = radix_csr_ff;
      thresh_csr_in = thresh_csr_ff;
      radix_in      = radix_ff;
      whole_in      = whole_ff;
      frac_in       = frac_ff;
      frac_more_in  = frac_more_ff;
      depth_in      = depth_ff;
      frac_cnt_in   = frac_cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = 1'b0;
      push          = 1'b0;
      div_start     = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_RADIX:     radix_csr_in  = csr_write_data[RADIX_W-1:0];
            CSR_THRESHOLD: thresh_csr_in = csr_write_data[THRESHOLD_W-1:0];
            default:       ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               radix_in     = radix_eff;
               whole_in     = req_whole_value;
               frac_in      = req_fraction_value;
               frac_more_in = req_fraction_value > thresh_csr_ff;
               depth_in     = '0;
               state_in     = S_DIV_START;
            end
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_status.done) begin
               push     = 1'b1;
               depth_in = depth_ff + STACK_CNT_W'(1);
               whole_in = div_status.quotient;
               state_in = (div_status.quotient == '0) ? S_WHOLE : S_DIV_START;
            end
         end
         S_WHOLE: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = digit_to_ascii(digit_stack[pop_idx]);
            depth_in     = depth_ff - STACK_CNT_W'(1);
            if (depth_ff == STACK_CNT_W'(1)) begin
               rsp_last_in = !frac_more_ff;
               state_in    = frac_more_ff ? S_DOT : S_IDLE;
            end
         end
         S_DOT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_POINT;
            frac_cnt_in  = '0;
            state_in     = S_FRAC;
         end
         S_FRAC: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = digit_to_ascii(product[PRODUCT_W-1:FRACTION_BITS]);
            frac_in      = frac_next;
            frac_cnt_in  = frac_cnt_ff + FRAC_CNT_W'(1);
            if (frac_cnt_ff == FRAC_CNT_W'(FRACTION_DIGITS - 1) ||
                frac_next <= thresh_csr_ff) begin
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         radix_csr_ff  <= RADIX_RESET;
         thresh_csr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radix_csr_ff  <= radix_csr_in;
         thresh_csr_ff <= thresh_csr_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
      end
      radix_ff     <= radix_in;
      whole_ff     <= whole_in;
      frac_ff      <= frac_in;
      frac_more_ff <= frac_more_in;
      depth_ff     <= depth_in;
      frac_cnt_ff  <= frac_cnt_in;
      rsp_char_ff  <= rsp_char_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         digit_stack[depth_ff[STACK_IDX_W-1:0]] <= div_status.remainder;
      end
   end

   assign busy           = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;

endmodule

// File: rtl/vrds_checker.sv
module vrds_checker
   import vrds_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [CHAR_W-1:0] rsp_digit_char,
   input logic              rsp_last_char
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after a number was taken");

   a_word_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("word issued while the block was idle");

   a_end_with_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_last_char)
      else $error("busy fell without a last word");

   a_quiet_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |=> !rsp_valid)
      else $error("word issued right after a last word");

   a_last_not_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_digit_char != CHAR_POINT)
      else $error("string ended on a radix point");

endmodule

bind value_to_radix_digit_string vrds_checker u_vrds_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last_char  (rsp_last_char)
);

// File: test/value_to_radix_digit_string_tb.sv
`timescale 1ns / 1ps

module value_to_radix_digit_string_tb;
   import vrds_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = CSR_INDEX_W'(3);
   localparam logic [CHAR_W-1:0]      CHAR_LOWER_A   = CHAR_W'("a");
   localparam logic [WHOLE_BITS-1:0]    WHOLE_MAX    = '1;
   localparam logic [FRACTION_BITS-1:0] FRACTION_MAX = '1;
   localparam int PROGRESS_LIMIT = 20000;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_ITEMS    = 20;

   typedef struct {
      logic [CHAR_W-1:0] digit_char;
      logic              last_char;
   } char_word_type;

   class digit_string_scoreboard;
      logic [RADIX_W-1:0]       radix     = RADIX_RESET;
      logic [THRESHOLD_W-1:0]   threshold = '0;
      char_word_type            pending_chars[$];
      int                       error_count = 0;

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         if (index == CSR_RADIX) begin
            radix = data[RADIX_W-1:0];
         end else if (index == CSR_THRESHOLD) begin
            threshold = data[THRESHOLD_W-1:0];
         end
      endfunction

      function logic [CHAR_W-1:0] char_of_digit(logic [RADIX_W-1:0] d);
         if (d < RADIX_W'(10)) begin
            return CHAR_ZERO + CHAR_W'(d);
         end
         return CHAR_LOWER_A + CHAR_W'(d) - CHAR_W'(10);
      endfunction

      function void note_number(logic [WHOLE_BITS-1:0] whole,
                                logic [FRACTION_BITS-1:0] frac);
         logic [RADIX_W-1:0]    base;
         logic [WHOLE_BITS-1:0] rest;
         logic [PRODUCT_W-1:0]  product;
         logic [CHAR_W-1:0]     reversed[$];
         logic [CHAR_W-1:0]     text[$];
         char_word_type         word;
         int                    count;
         base = radix;
         if (base < RADIX_MIN) begin
            base = RADIX_MIN;
         end else if (base > RADIX_MAX) begin
            base = RADIX_MAX;
         end
         rest = whole;
         do begin
            reversed.push_back(char_of_digit(RADIX_W'(rest % WHOLE_BITS'(base))));
            rest = rest / WHOLE_BITS'(base);
         end while (rest != '0);
         for (int i = reversed.size() - 1; i >= 0; i--) begin
            text.push_back(reversed[i]);
         end
         if (frac > threshold) begin
            text.push_back(CHAR_POINT);
            count = 0;
            while (count < FRACTION_DIGITS && frac > threshold) begin
               product = PRODUCT_W'(frac) * PRODUCT_W'(base);
               text.push_back(char_of_digit(product[PRODUCT_W-1:FRACTION_BITS]));
               frac = product[FRACTION_BITS-1:0];
               count++;
            end
         end
         foreach (text[i]) begin
            word.digit_char = text[i];
            word.last_char  = (i == text.size() - 1);
            pending_chars.push_back(word);
         end
      endfunction

      task report_mismatch(string what);
         $display("ERROR at %0t: %s", $realtime, what);
         error_count++;
      endtask

      task check_char(logic [CHAR_W-1:0] digit_char, logic last_char);
         char_word_type want;
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected word char=%02h last=%0b",
                                      digit_char, last_char));
         end else begin
            want = pending_chars.pop_front();
            if (digit_char !== want.digit_char) begin
               report_mismatch($sformatf("digit_char %02h, wanted %02h",
                                         digit_char, want.digit_char));
            end
            if (last_char !== want.last_char) begin
               report_mismatch($sformatf("last_char %0b, wanted %0b on char %02h",
                                         last_char, want.last_char, want.digit_char));
            end
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [WHOLE_BITS-1:0]    req_whole_value = '0;
   logic [FRACTION_BITS-1:0] req_fraction_value = '0;
   logic                     rsp_valid;
   logic [CHAR_W-1:0]        rsp_digit_char;
   logic                     rsp_last_char;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;

   digit_string_scoreboard sb = new;
   int idle_cycles = 0;
   int burst_left  = 0;
   bit progress;

   value_to_radix_digit_string u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_whole_value    (req_whole_value),
      .req_fraction_value (req_fraction_value),
      .rsp_valid          (rsp_valid),
      .rsp_digit_char     (rsp_digit_char),
      .rsp_last_char      (rsp_last_char),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         progress = 1'b0;
         if (start && !busy) begin
            sb.note_number(req_whole_value, req_fraction_value);
            progress = 1'b1;
         end
         if (rsp_valid) begin
            sb.check_char(rsp_digit_char, rsp_last_char);
            progress = 1'b1;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= PROGRESS_LIMIT) begin
            $display("Timeout: no progress for %0d cycles", PROGRESS_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      sb.write_register(index, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_index        = CSR_INDEX_W'($urandom);
      csr_write_data   = CSR_DATA_W'($urandom);
   endtask

   task automatic send_number(input logic [WHOLE_BITS-1:0] whole,
                              input logic [FRACTION_BITS-1:0] frac);
      int gap;
      if (burst_left == 0) begin
         start = 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         repeat (gap) begin
            req_whole_value    = WHOLE_BITS'($urandom);
            req_fraction_value = FRACTION_BITS'($urandom);
            @(negedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      req_whole_value    = whole;
      req_fraction_value = frac;
      start              = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic wait_until_idle();
      start      = 1'b0;
      burst_left = 0;
      while (sb.pending_chars.size() != 0 || busy) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [WHOLE_BITS-1:0] pick_whole();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return WHOLE_BITS'($urandom_range(0, 99));
         2:       return WHOLE_MAX;
         3:       return WHOLE_BITS'($urandom >> $urandom_range(1, 31));
         default: return WHOLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [FRACTION_BITS-1:0] pick_fraction(
      input logic [THRESHOLD_W-1:0] threshold);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return FRACTION_MAX;
         2:       return FRACTION_BITS'($urandom_range(1, 255) << $urandom_range(0, 16));
         3:       return threshold + FRACTION_BITS'($urandom_range(0, 2));
         4:       return FRACTION_BITS'($urandom_range(1, 15));
         default: return FRACTION_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [RADIX_W-1:0] pick_radix();
      case ($urandom_range(0, 9))
         0:       return RADIX_W'($urandom_range(0, 1));
         1:       return RADIX_W'($urandom_range(37, 63));
         2:       return RADIX_MIN;
         3:       return RADIX_MAX;
         default: return RADIX_W'($urandom_range(2, 36));
      endcase
   endfunction

   function automatic logic [THRESHOLD_W-1:0] pick_threshold();
      case ($urandom_range(0, 7))
         0, 1, 2: return '0;
         3:       return THRESHOLD_W'($urandom_range(1, 4095));
         4:       return '1;
         default: return THRESHOLD_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [RADIX_W-1:0]     radix_choice;
      logic [THRESHOLD_W-1:0] threshold_choice;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      csr_write(CSR_SPARE_LOW, 24'hFFFFFF);
      csr_write(CSR_SPARE_HIGH, 24'h000003);
      send_number('0, '0);
      send_number(WHOLE_MAX, FRACTION_MAX);
      send_number(31'd123, 24'h800000);
      send_number('0, 24'h000001);
      send_number(31'd1000000, 24'h400000);

      wait_until_idle();
      csr_write(CSR_RADIX, 24'hFFFFC2);
      send_number(WHOLE_MAX, '0);
      send_number('0, FRACTION_MAX);
      send_number(31'd5, 24'hA00000);

      wait_until_idle();
      csr_write(CSR_RADIX, CSR_DATA_W'(RADIX_MAX));
      send_number(WHOLE_MAX, FRACTION_MAX);
      send_number(31'd35, 24'h123456);

      wait_until_idle();
      csr_write(CSR_RADIX, 24'd0);
      send_number(31'd255, 24'h0F0F0F);
      wait_until_idle();
      csr_write(CSR_RADIX, 24'd1);
      send_number(31'd7, 24'h555555);
      wait_until_idle();
      csr_write(CSR_RADIX, 24'd37);
      send_number(31'd1295, 24'hABCDEF);
      wait_until_idle();
      csr_write(CSR_RADIX, 24'd63);
      send_number(31'd36, 24'h000001);

      wait_until_idle();
      csr_write(CSR_RADIX, 24'd16);
      csr_write(CSR_THRESHOLD, 24'hFFFFFF);
      send_number(31'hABCDEF, FRACTION_MAX);
      wait_until_idle();
      csr_write(CSR_THRESHOLD, 24'h100000);
      send_number(31'd1, 24'h100000);
      send_number(31'd1, 24'h100001);
      send_number(31'd1, 24'h180000);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_until_idle();
         radix_choice     = pick_radix();
         threshold_choice = pick_threshold();
         if ($urandom_range(0, 1) == 0) begin
            csr_write(CSR_THRESHOLD, threshold_choice);
            csr_write(CSR_RADIX, {(CSR_DATA_W - RADIX_W)'($urandom), radix_choice});
         end else begin
            csr_write(CSR_RADIX, {(CSR_DATA_W - RADIX_W)'($urandom), radix_choice});
            csr_write(CSR_THRESHOLD, threshold_choice);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_number(pick_whole(), pick_fraction(threshold_choice));
         end
      end

      wait_until_idle();
      repeat (50) @(negedge clock);
      if (sb.error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/vrds_pkg.sv
rtl/vrds_divider.sv
rtl/value_to_radix_digit_string.sv
rtl/vrds_checker.sv
test/value_to_radix_digit_string_tb.sv
